/* rtl/cbc_pkg.sv */
// Shared types and constants of the cartridge bank controller.
package cbc_pkg;

  localparam int RAM_DEPTH_DEF     = 32768;
  localparam int ROM_BANK_BITS_DEF = 7;

  localparam int ADDR_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int ROM_ADDR_W  = 21;
  localparam int RTC_REG_W   = 4;
  localparam int MASK_W      = 7;
  localparam int ROM_BYTES_W = 22;
  localparam int RAM_BYTES_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 22;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 48;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA      = 3'd0,
    KIND_ROM       = 3'd1,
    KIND_RTC_READ  = 3'd2,
    KIND_RTC_WRITE = 3'd3,
    KIND_LATCH     = 3'd4,
    KIND_NONE      = 3'd5
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BYTES     = 2'd2;

  localparam logic [MASK_W-1:0]      ROM_BANK_MASK_RST = 7'h7F;
  localparam logic [ROM_BYTES_W-1:0] ROM_BYTES_RST     = 22'h200000;
  localparam logic [RAM_BYTES_W-1:0] RAM_BYTES_RST     = 16'h8000;

  // Address regions by addr[15:13]
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_BANK   = 3'd1;
  localparam logic [2:0] REG_SELECT = 3'd2;
  localparam logic [2:0] REG_LATCH  = 3'd3;
  localparam logic [2:0] REG_RAM    = 3'd5;

  localparam logic [3:0]        ENABLE_KEY   = 4'hA;
  localparam logic [3:0]        SEL_CLOCK_LO = 4'h8;
  localparam logic [3:0]        SEL_CLOCK_HI = 4'hC;
  localparam logic [BYTE_W-1:0] FILL_BYTE    = 8'hFF;

  typedef struct packed {
    logic load;
    logic exec;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

/* rtl/cbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/cbc_ctrl.sv */
// Control state machine: RAM clear sweep, request accept, execute, result hand-off.
module cbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output cbc_pkg::cmd_t cmd,
  input  cbc_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  assign cmd.load  = accept;
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.clear = (state_r == S_CLEAR);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/cbc_dp.sv */
// Datapath: configuration, bank state, address decode, external RAM and result registers.
module cbc_dp #(
  parameter int RAM_DEPTH     = cbc_pkg::RAM_DEPTH_DEF,
  parameter int ROM_BANK_BITS = cbc_pkg::ROM_BANK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbc_pkg::cmd_t                     cmd,
  output cbc_pkg::sts_t                     sts,
  input  logic                              req_func,
  input  logic [cbc_pkg::ADDR_W-1:0]        req_address,
  input  logic [cbc_pkg::BYTE_W-1:0]        req_write_data,
  input  logic                              cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic [cbc_pkg::KIND_W-1:0]        res_kind,
  output logic [cbc_pkg::BYTE_W-1:0]        res_read_data,
  output logic [cbc_pkg::ROM_ADDR_W-1:0]    res_rom_address,
  output logic [cbc_pkg::RTC_REG_W-1:0]     res_rtc_register,
  output logic [cbc_pkg::BYTE_W-1:0]        res_forwarded_value,
  output logic                              res_ram_dirty
);

  localparam int         RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [16:0] DEPTH_LIM = 17'(RAM_DEPTH);

  // Request
  logic                       func_r;
  logic [cbc_pkg::ADDR_W-1:0] addr_r;
  logic [cbc_pkg::BYTE_W-1:0] data_r;

  // Configuration
  logic [cbc_pkg::MASK_W-1:0]      rom_bank_mask_r;
  logic [cbc_pkg::ROM_BYTES_W-1:0] rom_bytes_r;
  logic [cbc_pkg::RAM_BYTES_W-1:0] ram_bytes_r;

  // Mapper state
  logic                     bank_enable_r, bank_enable_nxt;
  logic [ROM_BANK_BITS-1:0] rom_bank_r, rom_bank_nxt;
  logic [3:0]               sel_r, sel_nxt;
  logic                     dirty_r, dirty_nxt;

  // Clear sweep
  logic [RAM_AW-1:0] clr_cnt_r;

  // Result
  cbc_pkg::kind_t                kind_r, kind_nxt;
  logic [cbc_pkg::BYTE_W-1:0]     rd_r, rd_nxt;
  logic                          rd_ram_r, rd_ram_nxt;
  logic [cbc_pkg::ROM_ADDR_W-1:0] romad_r, romad_nxt;
  logic [cbc_pkg::RTC_REG_W-1:0]  reg_r, reg_nxt;
  logic [cbc_pkg::BYTE_W-1:0]     fwd_r, fwd_nxt;

  // Decode
  logic [2:0]                     region;
  logic [15:0]                    ram_off;
  logic                           ram_ok;
  logic                           clock_sel;
  logic [ROM_BANK_BITS-1:0]       bank_masked;
  logic [cbc_pkg::ROM_ADDR_W-1:0] banked_off;
  logic                           ram_we, ram_re;
  logic [RAM_AW-1:0]              ram_waddr;
  logic [cbc_pkg::BYTE_W-1:0]     ram_wdata, ram_rdata;

  assign region      = addr_r[15:13];
  assign ram_off     = {sel_r[2:0], addr_r[12:0]};
  assign ram_ok      = !sel_r[3] && ({1'b0, ram_off} < {1'b0, ram_bytes_r})
                       && ({1'b0, ram_off} < DEPTH_LIM);
  assign clock_sel   = sel_r inside {[cbc_pkg::SEL_CLOCK_LO : cbc_pkg::SEL_CLOCK_HI]};
  assign bank_masked = data_r[ROM_BANK_BITS-1:0] & rom_bank_mask_r[ROM_BANK_BITS-1:0];
  assign banked_off  = cbc_pkg::ROM_ADDR_W'({rom_bank_r, addr_r[13:0]});

  assign sts.clear_last = (clr_cnt_r == RAM_AW'(RAM_DEPTH - 1));

  always_comb begin
    bank_enable_nxt = bank_enable_r;
    rom_bank_nxt    = rom_bank_r;
    sel_nxt         = sel_r;
    dirty_nxt       = dirty_r;
    kind_nxt        = cbc_pkg::KIND_NONE;
    rd_nxt          = '0;
    rd_ram_nxt      = 1'b0;
    romad_nxt       = '0;
    reg_nxt         = '0;
    fwd_nxt         = '0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    if (func_r) begin
      case (region)
        cbc_pkg::REG_ENABLE: begin
          bank_enable_nxt = (data_r[3:0] == cbc_pkg::ENABLE_KEY);
        end
        cbc_pkg::REG_BANK: begin
          rom_bank_nxt = (bank_masked == '0) ? ROM_BANK_BITS'(1) : bank_masked;
        end
        cbc_pkg::REG_SELECT: begin
          sel_nxt = data_r[3:0];
        end
        cbc_pkg::REG_LATCH: begin
          kind_nxt = cbc_pkg::KIND_LATCH;
          fwd_nxt  = data_r;
        end
        cbc_pkg::REG_RAM: begin
          if (bank_enable_r) begin
            if (ram_ok) begin
              ram_we    = 1'b1;
              dirty_nxt = 1'b1;
            end else if (clock_sel) begin
              kind_nxt  = cbc_pkg::KIND_RTC_WRITE;
              reg_nxt   = sel_r;
              fwd_nxt   = data_r;
              dirty_nxt = 1'b1;
            end
          end
        end
        default: begin
          kind_nxt = cbc_pkg::KIND_NONE;
        end
      endcase
    end else begin
      kind_nxt = cbc_pkg::KIND_DATA;
      rd_nxt   = cbc_pkg::FILL_BYTE;
      case (region)
        cbc_pkg::REG_ENABLE, cbc_pkg::REG_BANK: begin
          if ({6'd0, addr_r} < rom_bytes_r) begin
            kind_nxt  = cbc_pkg::KIND_ROM;
            rd_nxt    = '0;
            romad_nxt = cbc_pkg::ROM_ADDR_W'(addr_r);
          end
        end
        cbc_pkg::REG_SELECT, cbc_pkg::REG_LATCH: begin
          if ({1'b0, banked_off} < rom_bytes_r) begin
            kind_nxt  = cbc_pkg::KIND_ROM;
            rd_nxt    = '0;
            romad_nxt = banked_off;
          end
        end
        cbc_pkg::REG_RAM: begin
          if (bank_enable_r) begin
            if (ram_ok) begin
              ram_re     = 1'b1;
              rd_ram_nxt = 1'b1;
            end else if (clock_sel) begin
              kind_nxt = cbc_pkg::KIND_RTC_READ;
              rd_nxt   = '0;
              reg_nxt  = sel_r;
            end
          end
        end
        default: begin
          rd_nxt = cbc_pkg::FILL_BYTE;
        end
      endcase
    end
  end

  assign ram_waddr = cmd.clear ? clr_cnt_r : ram_off[RAM_AW-1:0];
  assign ram_wdata = cmd.clear ? '0 : data_r;

  cbc_ram #(
    .WIDTH (cbc_pkg::BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.clear || (cmd.exec && ram_we)),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.exec && ram_re),
    .raddr (ram_off[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_mask_r <= cbc_pkg::ROM_BANK_MASK_RST;
      rom_bytes_r     <= cbc_pkg::ROM_BYTES_RST;
      ram_bytes_r     <= cbc_pkg::RAM_BYTES_RST;
      bank_enable_r   <= 1'b0;
      rom_bank_r      <= ROM_BANK_BITS'(1);
      sel_r           <= '0;
      dirty_r         <= 1'b0;
      clr_cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cbc_pkg::CFG_ROM_BANK_MASK: rom_bank_mask_r <= cfg_wdata[cbc_pkg::MASK_W-1:0];
          cbc_pkg::CFG_ROM_BYTES:     rom_bytes_r     <= cfg_wdata;
          cbc_pkg::CFG_RAM_BYTES:     ram_bytes_r <= cfg_wdata[cbc_pkg::RAM_BYTES_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + RAM_AW'(1);
      end
      if (cmd.exec) begin
        bank_enable_r <= bank_enable_nxt;
        rom_bank_r    <= rom_bank_nxt;
        sel_r         <= sel_nxt;
        dirty_r       <= dirty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= req_func;
      addr_r <= req_address;
      data_r <= req_write_data;
    end
    if (cmd.exec) begin
      kind_r   <= kind_nxt;
      rd_r     <= rd_nxt;
      rd_ram_r <= rd_ram_nxt;
      romad_r  <= romad_nxt;
      reg_r    <= reg_nxt;
      fwd_r    <= fwd_nxt;
    end
  end

  assign res_kind            = kind_r;
  assign res_read_data       = rd_ram_r ? ram_rdata : rd_r;
  assign res_rom_address     = romad_r;
  assign res_rtc_register    = reg_r;
  assign res_forwarded_value = fwd_r;
  assign res_ram_dirty       = dirty_r;

endmodule

/* rtl/cartridge_bank_controller.sv */
// Top level of the cartridge bank controller: control state machine plus datapath.
// Each bus request gives one result. A request is accepted, decoded and run against
// the bank registers and the external RAM in the following cycle, and its result is
// offered on the out side the cycle after that. The next request is accepted in the
// cycle its predecessor's result is taken. After reset the external RAM is cleared to
// zero one byte per cycle, and in_tready stays low during the sweep; configuration
// writes are taken at any time but belong to idle periods. ROM data is not held here:
// a ROM read returns kind 1 with the byte address to fetch.
module cartridge_bank_controller #(
  parameter int RAM_DEPTH     = cbc_pkg::RAM_DEPTH_DEF,
  parameter int ROM_BANK_BITS = cbc_pkg::ROM_BANK_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] address, [23:16] write_data
  input  logic [cbc_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] func
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] read_data, [28:8] rom_address, [32:29] rtc_register,
  // [40:33] forwarded_value, [41] ram_dirty, [47:42] zero
  output logic [cbc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [2:0] kind
  output logic [cbc_pkg::KIND_W-1:0]         out_tuser,
  input  logic                               cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  cbc_pkg::cmd_t cmd;
  cbc_pkg::sts_t sts;

  logic [cbc_pkg::BYTE_W-1:0]     res_read_data;
  logic [cbc_pkg::ROM_ADDR_W-1:0] res_rom_address;
  logic [cbc_pkg::RTC_REG_W-1:0]  res_rtc_register;
  logic [cbc_pkg::BYTE_W-1:0]     res_forwarded_value;
  logic                           res_ram_dirty;

  cbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  cbc_dp #(
    .RAM_DEPTH     (RAM_DEPTH),
    .ROM_BANK_BITS (ROM_BANK_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .req_func            (in_tuser),
    .req_address         (in_tdata[15:0]),
    .req_write_data      (in_tdata[23:16]),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .res_kind            (out_tuser),
    .res_read_data       (res_read_data),
    .res_rom_address     (res_rom_address),
    .res_rtc_register    (res_rtc_register),
    .res_forwarded_value (res_forwarded_value),
    .res_ram_dirty       (res_ram_dirty)
  );

  assign out_tdata = {6'd0, res_ram_dirty, res_forwarded_value, res_rtc_register,
                      res_rom_address, res_read_data};

endmodule
